// ----- sv/rmnh_pkg.sv -----
// ============================================================================
// rmnh_pkg
// Shared types, constants and the product sequence of the ray/mesh nearest
// hit block.
// ============================================================================
`default_nettype none

package rmnh_pkg;

    localparam int COORD_W    = 32;
    localparam int FRAC_W     = 16;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int CROSS_W    = 2 * DIFF_W + 1;
    localparam int WIDE_W     = 3 * COORD_W + 8;
    localparam int NORM_W     = 16;
    localparam int NORM_SHIFT = 14;
    localparam int NQ_W       = NORM_SHIFT + 1;
    localparam int MAG_KEEP   = 30;
    localparam int SUM_W      = 64;
    localparam int LEN_W      = SUM_W / 2;
    localparam int REM_W      = LEN_W + 1;
    localparam int ROOT_STEPS = SUM_W / 2;
    localparam int PROD_W     = DIFF_W + FRAC_W + 1;
    localparam int N_UOPS     = 30;
    localparam int UOP_W      = 5;
    localparam int CNT_W      = 6;
    localparam int QDEPTH     = 2;
    localparam int CFG_IDX_W  = 3;

    localparam logic [FRAC_W:0] BEST_ONE = {1'b1, {FRAC_W{1'b0}}};

    localparam logic [CFG_IDX_W-1:0] CFG_START_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_END_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END_Z   = 3'd5;

    // operand selects of the multiply-accumulate sequence
    localparam logic [4:0] OP_U0 = 5'd0;
    localparam logic [4:0] OP_U1 = 5'd1;
    localparam logic [4:0] OP_U2 = 5'd2;
    localparam logic [4:0] OP_V0 = 5'd3;
    localparam logic [4:0] OP_V1 = 5'd4;
    localparam logic [4:0] OP_V2 = 5'd5;
    localparam logic [4:0] OP_W0 = 5'd6;
    localparam logic [4:0] OP_W1 = 5'd7;
    localparam logic [4:0] OP_W2 = 5'd8;
    localparam logic [4:0] OP_D0 = 5'd9;
    localparam logic [4:0] OP_D1 = 5'd10;
    localparam logic [4:0] OP_D2 = 5'd11;
    localparam logic [4:0] OP_N0 = 5'd12;
    localparam logic [4:0] OP_N1 = 5'd13;
    localparam logic [4:0] OP_N2 = 5'd14;
    localparam logic [4:0] OP_Q0 = 5'd15;
    localparam logic [4:0] OP_Q1 = 5'd16;
    localparam logic [4:0] OP_Q2 = 5'd17;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [WIDE_W-1:0]  t_wide;
    typedef logic signed [NORM_W-1:0]  t_norm;
    typedef t_coord [2:0] t_vec3;
    typedef t_diff  [2:0] t_dvec3;

    typedef struct packed {
        t_coord corner_a_x;
        t_coord corner_a_y;
        t_coord corner_a_z;
        t_coord corner_b_x;
        t_coord corner_b_y;
        t_coord corner_b_z;
        t_coord corner_c_x;
        t_coord corner_c_y;
        t_coord corner_c_z;
        logic   final_triangle;
    } t_in;

    typedef struct packed {
        logic [1:0] triangle_status;
        logic       became_nearest;
        logic       have_hit;
        t_coord     hit_x;
        t_coord     hit_y;
        t_coord     hit_z;
        t_norm      normal_x;
        t_norm      normal_y;
        t_norm      normal_z;
        logic       mesh_done;
    } t_out;

    typedef struct packed {
        t_dvec3 u;
        t_dvec3 v;
        t_dvec3 w;
        logic   last;
    } t_work;

    typedef enum logic [1:0] {
        ST_MISS   = 2'd0,
        ST_HIT    = 2'd1,
        ST_DEGEN  = 2'd2,
        ST_PLANAR = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        WD_N0, WD_N1, WD_N2, WD_Q0, WD_Q1, WD_Q2, WD_B, WD_A, WD_S, WD_T
    } t_wdst;

    typedef struct packed {
        logic [4:0] x_sel;
        logic [4:0] y_sel;
        logic       sub;
        logic       last;
        t_wdst      dest;
    } t_uop;

    typedef enum logic [3:0] {
        BS_IDLE, BS_LOAD, BS_MUL, BS_SIGN, BS_CLASS, BS_DIV, BS_CMP, BS_PMUL,
        BS_PADD, BS_NMAG, BS_NSHIFT, BS_SQMUL, BS_SQADD, BS_SQRT, BS_NDIV, BS_EMIT
    } t_bstate;

    function automatic t_diff sx_coord(input t_coord c);
        return {c[COORD_W-1], c};
    endfunction

    // n = u x v, B = d.n, A = -(w.n), q = w x v, S = d.q, q = u x w, T = d.q
    function automatic t_uop uop_rom(input logic [UOP_W-1:0] idx);
        t_uop r;
        case (idx)
            5'd0:  r = '{OP_U1, OP_V2, 1'b0, 1'b0, WD_N0};
            5'd1:  r = '{OP_U2, OP_V1, 1'b1, 1'b1, WD_N0};
            5'd2:  r = '{OP_U2, OP_V0, 1'b0, 1'b0, WD_N1};
            5'd3:  r = '{OP_U0, OP_V2, 1'b1, 1'b1, WD_N1};
            5'd4:  r = '{OP_U0, OP_V1, 1'b0, 1'b0, WD_N2};
            5'd5:  r = '{OP_U1, OP_V0, 1'b1, 1'b1, WD_N2};
            5'd6:  r = '{OP_D0, OP_N0, 1'b0, 1'b0, WD_B};
            5'd7:  r = '{OP_D1, OP_N1, 1'b0, 1'b0, WD_B};
            5'd8:  r = '{OP_D2, OP_N2, 1'b0, 1'b1, WD_B};
            5'd9:  r = '{OP_W0, OP_N0, 1'b1, 1'b0, WD_A};
            5'd10: r = '{OP_W1, OP_N1, 1'b1, 1'b0, WD_A};
            5'd11: r = '{OP_W2, OP_N2, 1'b1, 1'b1, WD_A};
            5'd12: r = '{OP_W1, OP_V2, 1'b0, 1'b0, WD_Q0};
            5'd13: r = '{OP_W2, OP_V1, 1'b1, 1'b1, WD_Q0};
            5'd14: r = '{OP_W2, OP_V0, 1'b0, 1'b0, WD_Q1};
            5'd15: r = '{OP_W0, OP_V2, 1'b1, 1'b1, WD_Q1};
            5'd16: r = '{OP_W0, OP_V1, 1'b0, 1'b0, WD_Q2};
            5'd17: r = '{OP_W1, OP_V0, 1'b1, 1'b1, WD_Q2};
            5'd18: r = '{OP_D0, OP_Q0, 1'b0, 1'b0, WD_S};
            5'd19: r = '{OP_D1, OP_Q1, 1'b0, 1'b0, WD_S};
            5'd20: r = '{OP_D2, OP_Q2, 1'b0, 1'b1, WD_S};
            5'd21: r = '{OP_U1, OP_W2, 1'b0, 1'b0, WD_Q0};
            5'd22: r = '{OP_U2, OP_W1, 1'b1, 1'b1, WD_Q0};
            5'd23: r = '{OP_U2, OP_W0, 1'b0, 1'b0, WD_Q1};
            5'd24: r = '{OP_U0, OP_W2, 1'b1, 1'b1, WD_Q1};
            5'd25: r = '{OP_U0, OP_W1, 1'b0, 1'b0, WD_Q2};
            5'd26: r = '{OP_U1, OP_W0, 1'b1, 1'b1, WD_Q2};
            5'd27: r = '{OP_D0, OP_Q0, 1'b0, 1'b0, WD_T};
            5'd28: r = '{OP_D1, OP_Q1, 1'b0, 1'b0, WD_T};
            5'd29: r = '{OP_D2, OP_Q2, 1'b0, 1'b1, WD_T};
            default: r = '{OP_U0, OP_U0, 1'b0, 1'b0, WD_N0};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/rmnh_front.sv -----
// ============================================================================
// rmnh_front
// Input stage: takes a triangle transaction and forms its edge vectors and
// the offset of the ray start from the first corner.
// ============================================================================
`default_nettype none

module rmnh_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rmnh_pkg::t_vec3 i_ray_start,
    input  logic            i_in_valid,
    input  rmnh_pkg::t_in   i_in_data,
    output logic            o_in_stall,
    output logic            o_push_valid,
    output rmnh_pkg::t_work o_push_item,
    input  logic            i_push_ready
);
    import rmnh_pkg::*;

    logic   r_valid;
    t_work  r_item;
    t_work  n_item;
    logic   take;
    logic   push;
    t_dvec3 a;
    t_dvec3 b;
    t_dvec3 c;
    t_dvec3 o;

    assign push       = r_valid && i_push_ready;
    assign o_in_stall = r_valid && !i_push_ready;
    assign take       = i_in_valid && !o_in_stall;

    always_comb begin
        a[0] = sx_coord(i_in_data.corner_a_x);
        a[1] = sx_coord(i_in_data.corner_a_y);
        a[2] = sx_coord(i_in_data.corner_a_z);
        b[0] = sx_coord(i_in_data.corner_b_x);
        b[1] = sx_coord(i_in_data.corner_b_y);
        b[2] = sx_coord(i_in_data.corner_b_z);
        c[0] = sx_coord(i_in_data.corner_c_x);
        c[1] = sx_coord(i_in_data.corner_c_y);
        c[2] = sx_coord(i_in_data.corner_c_z);
        for (int i = 0; i < 3; i++) begin
            o[i]        = sx_coord(i_ray_start[i]);
            n_item.u[i] = b[i] - a[i];
            n_item.v[i] = c[i] - a[i];
            n_item.w[i] = o[i] - a[i];
        end
        n_item.last = i_in_data.final_triangle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

    assign o_push_valid = r_valid;
    assign o_push_item  = r_item;

endmodule

`default_nettype wire

// ----- sv/rmnh_queue.sv -----
// ============================================================================
// rmnh_queue
// Short work queue between the input stage and the intersection engine.
// ============================================================================
`default_nettype none

module rmnh_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    input  rmnh_pkg::t_work i_push_item,
    output logic            o_push_ready,
    output logic            o_pop_valid,
    output rmnh_pkg::t_work o_pop_item,
    input  logic            i_pop
);
    import rmnh_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_QW = $clog2(QDEPTH + 1);

    t_work             r_mem [QDEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_QW-1:0] r_count;
    logic              push;

    assign o_push_ready = (r_count != CNT_QW'(QDEPTH));
    assign push         = i_push_valid && o_push_ready;
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_QW'(QDEPTH))
        else $error("queue overfilled");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ----- sv/rmnh_back.sv -----
// ============================================================================
// rmnh_back
// Intersection engine: shift-add multiply-accumulate sequence for the exact
// plane and barycentric terms, classification, ray parameter divide, nearest
// update, hit point and unit normal, and the result register.
// ============================================================================
`default_nettype none

module rmnh_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rmnh_pkg::t_vec3 i_ray_start,
    input  rmnh_pkg::t_vec3 i_ray_end,
    input  logic            i_q_valid,
    input  rmnh_pkg::t_work i_q_item,
    output logic            o_q_pop,
    output logic            o_out_valid,
    output rmnh_pkg::t_out  o_out_data,
    input  logic            i_out_stall
);
    import rmnh_pkg::*;

    t_bstate r_state;
    t_bstate n_state;

    t_work              r_work;
    logic [UOP_W-1:0]   r_step;
    logic [CNT_W-1:0]   r_cnt;
    logic [1:0]         r_axis;
    t_diff              r_x;
    t_wide              r_y;
    t_wide              r_acc;
    t_wide              r_n [3];
    t_wide              r_q [3];
    t_wide              r_bb;
    t_wide              r_aa;
    t_wide              r_ss;
    t_wide              r_tt;
    t_status            r_status;
    logic               r_became;
    logic [WIDE_W-1:0]  r_rem;
    logic [FRAC_W:0]    r_rq;
    logic signed [PROD_W-1:0] r_prod;
    logic [CROSS_W-1:0] r_mag [3];
    logic [2:0]         r_nneg;
    logic [2*MAG_KEEP-1:0] r_sq;
    logic [SUM_W-1:0]   r_sum;
    logic [SUM_W-1:0]   r_root;
    logic [SUM_W-1:0]   r_sqbit;
    logic [REM_W-1:0]   r_nrem;
    logic [NQ_W-1:0]    r_nq;

    logic [FRAC_W:0]    r_best_param;
    logic               r_found;
    t_vec3              r_best_point;
    t_norm              r_best_norm [3];
    logic               r_out_valid;
    t_out               r_out;

    t_dvec3 dv;
    t_uop   uop;
    t_diff  x_op;
    t_diff  yd_op;
    t_wide  y_op;
    t_wide  term;
    logic   neg;
    t_wide  acc_sum;
    logic   mul_done;
    logic   out_load;

    logic   n_zero;
    logic   b_zero;
    logic   a_zero;
    t_wide  st_sum;
    logic   s_le_b;
    logic   st_le_b;
    logic   a_ge_2b;
    logic   in_tri;
    logic   cls_hit;
    t_status cls_status;

    logic [WIDE_W-1:0]  rem_cur;
    logic               div_ge;
    logic               take_best;
    logic signed [PROD_W-1:0] p_off;
    logic [CROSS_W-1:0] mag_or;
    logic               mag_big;
    logic [MAG_KEEP-1:0] m_low;
    logic [SUM_W:0]     root_diff;
    logic               root_ge;
    logic [LEN_W-1:0]   len;
    logic [REM_W-1:0]   nrem_cur;
    logic               nd_ge;
    logic [NQ_W-1:0]    nq_next;
    logic [NORM_W-1:0]  c_mag;
    t_norm              c_norm;

    function automatic t_diff pick_diff(input logic [4:0] sel, input t_work w,
                                        input t_dvec3 d);
        t_diff r;
        case (sel)
            OP_U0:   r = w.u[0];
            OP_U1:   r = w.u[1];
            OP_U2:   r = w.u[2];
            OP_V0:   r = w.v[0];
            OP_V1:   r = w.v[1];
            OP_V2:   r = w.v[2];
            OP_W0:   r = w.w[0];
            OP_W1:   r = w.w[1];
            OP_W2:   r = w.w[2];
            OP_D0:   r = d[0];
            OP_D1:   r = d[1];
            OP_D2:   r = d[2];
            default: r = '0;
        endcase
        return r;
    endfunction

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dv[i] = sx_coord(i_ray_end[i]) - sx_coord(i_ray_start[i]);
        end
    end

    // multiply-accumulate datapath, one multiplier bit per cycle
    assign uop   = uop_rom(r_step);
    assign x_op  = pick_diff(uop.x_sel, r_work, dv);
    assign yd_op = pick_diff(uop.y_sel, r_work, dv);

    always_comb begin
        case (uop.y_sel)
            OP_N0:   y_op = r_n[0];
            OP_N1:   y_op = r_n[1];
            OP_N2:   y_op = r_n[2];
            OP_Q0:   y_op = r_q[0];
            OP_Q1:   y_op = r_q[1];
            OP_Q2:   y_op = r_q[2];
            default: y_op = {{(WIDE_W-DIFF_W){yd_op[DIFF_W-1]}}, yd_op};
        endcase
    end

    assign mul_done = (r_cnt == CNT_W'(DIFF_W - 1));
    assign term     = r_x[0] ? r_y : '0;
    assign neg      = mul_done ^ uop.sub;
    assign acc_sum  = r_acc + (term ^ {WIDE_W{neg}}) + WIDE_W'(neg);

    // classification
    always_comb begin
        n_zero  = (r_n[0] == '0) && (r_n[1] == '0) && (r_n[2] == '0);
        b_zero  = (r_bb == '0);
        a_zero  = (r_aa == '0);
        st_sum  = r_ss + r_tt;
        s_le_b  = (r_ss <= r_bb);
        st_le_b = (st_sum <= r_bb);
        a_ge_2b = (r_aa >= $signed({r_bb[WIDE_W-2:0], 1'b0}));
        in_tri  = !r_aa[WIDE_W-1] && !r_ss[WIDE_W-1] && !r_tt[WIDE_W-1] &&
                  s_le_b && st_le_b;
        cls_hit = !n_zero && !b_zero && in_tri;
        if (n_zero) begin
            cls_status = ST_DEGEN;
        end else if (b_zero) begin
            cls_status = a_zero ? ST_PLANAR : ST_MISS;
        end else if (in_tri) begin
            cls_status = ST_HIT;
        end else begin
            cls_status = ST_MISS;
        end
    end

    assign rem_cur   = (r_cnt == '0) ? r_rem : {r_rem[WIDE_W-2:0], 1'b0};
    assign div_ge    = (rem_cur >= r_bb);
    assign take_best = (r_rq < r_best_param);
    assign p_off     = r_prod >>> FRAC_W;
    assign mag_or    = r_mag[0] | r_mag[1] | r_mag[2];
    assign mag_big   = |mag_or[CROSS_W-1:MAG_KEEP];
    assign m_low     = r_mag[r_axis][MAG_KEEP-1:0];
    assign root_diff = {1'b0, r_sum} - {1'b0, (r_root | r_sqbit)};
    assign root_ge   = !root_diff[SUM_W];
    assign len       = r_root[LEN_W-1:0];
    assign nrem_cur  = (r_cnt == '0) ? REM_W'(m_low) : {r_nrem[REM_W-2:0], 1'b0};
    assign nd_ge     = (nrem_cur >= {1'b0, len});
    assign nq_next   = {r_nq[NQ_W-2:0], nd_ge};
    assign c_mag     = (len == '0) ? '0 : NORM_W'(nq_next);
    assign c_norm    = r_nneg[r_axis] ? -$signed(c_mag) : $signed(c_mag);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE:   if (i_q_valid) n_state = BS_LOAD;
            BS_LOAD:   n_state = BS_MUL;
            BS_MUL: begin
                if (mul_done) begin
                    n_state = (r_step == UOP_W'(N_UOPS - 1)) ? BS_SIGN : BS_LOAD;
                end
            end
            BS_SIGN:   n_state = BS_CLASS;
            BS_CLASS: begin
                if (cls_hit) begin
                    n_state = a_ge_2b ? BS_CMP : BS_DIV;
                end else begin
                    n_state = BS_EMIT;
                end
            end
            BS_DIV:    if (r_cnt == CNT_W'(FRAC_W)) n_state = BS_CMP;
            BS_CMP:    n_state = take_best ? BS_PMUL : BS_EMIT;
            BS_PMUL:   n_state = BS_PADD;
            BS_PADD:   n_state = (r_axis == 2'd2) ? BS_NMAG : BS_PMUL;
            BS_NMAG:   n_state = BS_NSHIFT;
            BS_NSHIFT: if (!mag_big) n_state = BS_SQMUL;
            BS_SQMUL:  n_state = BS_SQADD;
            BS_SQADD:  n_state = (r_axis == 2'd2) ? BS_SQRT : BS_SQMUL;
            BS_SQRT:   if (r_cnt == CNT_W'(ROOT_STEPS - 1)) n_state = BS_NDIV;
            BS_NDIV: begin
                if ((r_cnt == CNT_W'(NORM_SHIFT)) && (r_axis == 2'd2)) n_state = BS_EMIT;
            end
            BS_EMIT:   if (out_load) n_state = BS_IDLE;
            default:   n_state = BS_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_q_pop  = 1'b0;
        out_load = 1'b0;
        case (r_state)
            BS_IDLE: o_q_pop  = i_q_valid;
            BS_EMIT: out_load = !r_out_valid || !i_out_stall;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // nearest-hit state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_param <= BEST_ONE;
            r_found      <= 1'b0;
            r_best_point <= '0;
            for (int i = 0; i < 3; i++) r_best_norm[i] <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                BS_CMP: begin
                    if (take_best) begin
                        r_best_param <= r_rq;
                        r_found      <= 1'b1;
                    end
                end
                BS_PADD: begin
                    r_best_point[r_axis] <= i_ray_start[r_axis] + p_off[COORD_W-1:0];
                end
                BS_NDIV: begin
                    if (r_cnt == CNT_W'(NORM_SHIFT)) r_best_norm[r_axis] <= c_norm;
                end
                BS_EMIT: begin
                    if (out_load && r_work.last) begin
                        r_best_param <= BEST_ONE;
                        r_found      <= 1'b0;
                        r_best_point <= '0;
                        for (int i = 0; i < 3; i++) r_best_norm[i] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.triangle_status <= r_status;
            r_out.became_nearest  <= r_became;
            r_out.have_hit        <= r_found;
            r_out.hit_x           <= r_best_point[0];
            r_out.hit_y           <= r_best_point[1];
            r_out.hit_z           <= r_best_point[2];
            r_out.normal_x        <= r_best_norm[0];
            r_out.normal_y        <= r_best_norm[1];
            r_out.normal_z        <= r_best_norm[2];
            r_out.mesh_done       <= r_work.last;
        end
    end

    // working datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            BS_IDLE: begin
                if (i_q_valid) begin
                    r_work   <= i_q_item;
                    r_step   <= '0;
                    r_acc    <= '0;
                    r_became <= 1'b0;
                end
            end
            BS_LOAD: begin
                r_x   <= x_op;
                r_y   <= y_op;
                r_cnt <= '0;
            end
            BS_MUL: begin
                r_x   <= r_x >>> 1;
                r_y   <= r_y <<< 1;
                r_cnt <= r_cnt + 1'b1;
                if (mul_done) begin
                    r_step <= r_step + 1'b1;
                    if (uop.last) begin
                        r_acc <= '0;
                        case (uop.dest)
                            WD_N0:   r_n[0] <= acc_sum;
                            WD_N1:   r_n[1] <= acc_sum;
                            WD_N2:   r_n[2] <= acc_sum;
                            WD_Q0:   r_q[0] <= acc_sum;
                            WD_Q1:   r_q[1] <= acc_sum;
                            WD_Q2:   r_q[2] <= acc_sum;
                            WD_B:    r_bb   <= acc_sum;
                            WD_A:    r_aa   <= acc_sum;
                            WD_S:    r_ss   <= acc_sum;
                            WD_T:    r_tt   <= acc_sum;
                            default: ;
                        endcase
                    end else begin
                        r_acc <= acc_sum;
                    end
                end else begin
                    r_acc <= acc_sum;
                end
            end
            BS_SIGN: begin
                if (r_bb[WIDE_W-1]) begin
                    r_bb <= -r_bb;
                    r_aa <= -r_aa;
                    r_ss <= -r_ss;
                    r_tt <= -r_tt;
                end
            end
            BS_CLASS: begin
                r_status <= cls_status;
                r_rem    <= r_aa;
                r_cnt    <= '0;
                r_rq     <= a_ge_2b ? '1 : '0;
            end
            BS_DIV: begin
                r_rq  <= {r_rq[FRAC_W-1:0], div_ge};
                r_rem <= div_ge ? rem_cur - r_bb : rem_cur;
                r_cnt <= r_cnt + 1'b1;
            end
            BS_CMP: begin
                r_became <= take_best;
                r_axis   <= '0;
            end
            BS_PMUL: begin
                r_prod <= dv[r_axis] * $signed({1'b0, r_rq});
            end
            BS_PADD: begin
                r_axis <= r_axis + 1'b1;
            end
            BS_NMAG: begin
                for (int i = 0; i < 3; i++) begin
                    r_nneg[i] <= r_n[i][WIDE_W-1];
                    r_mag[i]  <= r_n[i][WIDE_W-1] ? CROSS_W'(-r_n[i]) : CROSS_W'(r_n[i]);
                end
            end
            BS_NSHIFT: begin
                if (mag_big) begin
                    for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 1;
                end
                r_axis <= '0;
                r_sum  <= '0;
            end
            BS_SQMUL: begin
                r_sq <= m_low * m_low;
            end
            BS_SQADD: begin
                r_sum  <= r_sum + SUM_W'(r_sq);
                r_axis <= r_axis + 1'b1;
                r_cnt  <= '0;
                r_root <= '0;
                r_sqbit <= SUM_W'(1) << (SUM_W - 2);
            end
            BS_SQRT: begin
                if (root_ge) begin
                    r_sum  <= root_diff[SUM_W-1:0];
                    r_root <= (r_root >> 1) | r_sqbit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_sqbit <= r_sqbit >> 2;
                if (r_cnt == CNT_W'(ROOT_STEPS - 1)) begin
                    r_cnt  <= '0;
                    r_axis <= '0;
                    r_nq   <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            BS_NDIV: begin
                r_nrem <= nd_ge ? nrem_cur - {1'b0, len} : nrem_cur;
                if (r_cnt == CNT_W'(NORM_SHIFT)) begin
                    r_cnt  <= '0;
                    r_nq   <= '0;
                    r_axis <= r_axis + 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                    r_nq  <= nq_next;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    a_found_param: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found == (r_best_param != BEST_ONE))
        else $error("found flag and best parameter disagree");
    a_became_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.became_nearest) |->
            ((o_out_data.triangle_status == ST_HIT) && o_out_data.have_hit))
        else $error("nearest update without a hit");
    a_pop_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state == BS_LOAD))
        else $error("popped transaction not started");
    a_mesh_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_work.last) |=> (!r_found && (r_best_param == BEST_ONE)))
        else $error("state not cleared after final triangle");
`endif

endmodule

`default_nettype wire

// ----- sv/ray_mesh_nearest_hit.sv -----
// ============================================================================
// ray_mesh_nearest_hit
// Nearest hit of a configured ray segment on a stream of triangles.
// ============================================================================
// Program the ray start and end (signed Q16.16) while the block is idle, then
// stream triangles; each transaction returns one result with the triangle's
// class and the nearest hit point and unit normal (Q1.14) so far, and the
// transaction flagged as final returns the answer and rearms the search.
// The engine forms 30 exact products in a shift-add multiply-accumulate unit
// at one multiplier bit per cycle; a hit adds the parameter divide (skipped
// when the parameter saturates) and compare, and a hit that becomes the
// nearest adds the hit point, normal scaling, square root and normal
// divides. A two-entry queue lets the input side run ahead.
`default_nettype none

module ray_mesh_nearest_hit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  rmnh_pkg::t_in                      i_in_data,
    output logic                               o_in_stall,
    output logic                               o_out_valid,
    output rmnh_pkg::t_out                     o_out_data,
    input  logic                               i_out_stall,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rmnh_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  rmnh_pkg::t_coord                   i_cfg_data
);
    import rmnh_pkg::*;

    t_vec3 r_start;
    t_vec3 r_end;
    logic  push_valid;
    t_work push_item;
    logic  push_ready;
    logic  pop_valid;
    t_work pop_item;
    logic  pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_end   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_START_X: r_start[0] <= i_cfg_data;
                CFG_START_Y: r_start[1] <= i_cfg_data;
                CFG_START_Z: r_start[2] <= i_cfg_data;
                CFG_END_X:   r_end[0]   <= i_cfg_data;
                CFG_END_Y:   r_end[1]   <= i_cfg_data;
                CFG_END_Z:   r_end[2]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rmnh_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ray_start  (r_start),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_in_stall   (o_in_stall),
        .o_push_valid (push_valid),
        .o_push_item  (push_item),
        .i_push_ready (push_ready)
    );

    rmnh_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_item  (push_item),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_item   (pop_item),
        .i_pop        (pop)
    );

    rmnh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ray_start (r_start),
        .i_ray_end   (r_end),
        .i_q_valid   (pop_valid),
        .i_q_item    (pop_item),
        .o_q_pop     (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

// ----- verif/ray_mesh_nearest_hit_tb.sv -----
// ============================================================================
// ray_mesh_nearest_hit_tb
// Self-checking bench: ray segments are programmed through the config port,
// then triangle streams (hits built on the ray, ties, in-plane, parallel,
// degenerate and raw random corners) run with random idling on both sides.
// Every result transaction is checked against an exact wide-integer predictor.
// ============================================================================
`default_nettype none

module ray_mesh_nearest_hit_tb;
    import rmnh_pkg::*;

    typedef logic signed [159:0] t_big;
    typedef struct packed { t_big x; t_big y; t_big z; } t_v3;

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int DRAIN_CYCLES   = 1400;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    t_in                  in_data = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    t_coord               cfg_data = '0;
    wire                  o_in_stall;
    wire                  o_out_valid;
    wire                  o_cfg_ready;
    t_out                 o_out_data;

    ray_mesh_nearest_hit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // predictor copy of registers and search state
    t_coord      ray_reg [6];
    logic [16:0] best_r = BEST_ONE;
    logic        found = 1'b0;
    t_coord      best_pt [3];
    t_norm       best_nrm [3];

    t_in  tri_q [$];
    t_out hit_q [$];
    int   errors = 0;
    int   idle_cycles = 0;

    initial begin
        for (int i = 0; i < 6; i++) ray_reg[i] = '0;
        for (int i = 0; i < 3; i++) begin
            best_pt[i] = '0;
            best_nrm[i] = '0;
        end
    end

    function automatic t_big sx(input t_coord c);
        t_big r;
        r = c;
        return r;
    endfunction

    function automatic t_v3 vsub(input t_v3 p, input t_v3 q);
        return '{p.x - q.x, p.y - q.y, p.z - q.z};
    endfunction

    function automatic t_v3 cross3(input t_v3 p, input t_v3 q);
        return '{p.y * q.z - p.z * q.y, p.z * q.x - p.x * q.z, p.x * q.y - p.y * q.x};
    endfunction

    function automatic t_big dot3(input t_v3 p, input t_v3 q);
        return p.x * q.x + p.y * q.y + p.z * q.z;
    endfunction

    function automatic longint unsigned isqrt(input longint unsigned x);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > x) bit_v >>= 2;
        while (bit_v != 0) begin
            if (x >= res + bit_v) begin
                x -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    function automatic void set_unit_normal(input t_v3 n);
        t_big            comp [3];
        t_big            mg [3];
        t_big            tmp;
        longint unsigned m [3];
        longint unsigned sum, len, c;
        int              top, sh;
        comp[0] = n.x;
        comp[1] = n.y;
        comp[2] = n.z;
        top = 0;
        for (int i = 0; i < 3; i++) begin
            mg[i] = comp[i] < 0 ? -comp[i] : comp[i];
            for (int b = 159; b >= 0; b--) begin
                if (mg[i][b]) begin
                    if (b + 1 > top) top = b + 1;
                    break;
                end
            end
        end
        sh = top > MAG_KEEP ? top - MAG_KEEP : 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            tmp = mg[i] >> sh;
            m[i] = tmp[63:0];
            sum += m[i] * m[i];
        end
        len = isqrt(sum);
        for (int i = 0; i < 3; i++) begin
            c = len != 0 ? (m[i] << NORM_SHIFT) / len : 0;
            best_nrm[i] = comp[i] < 0 ? -c[15:0] : c[15:0];
        end
    endfunction

    function automatic t_out nearest_hit_step(input t_in it);
        t_v3         a, b, c, o, e, u, v, d, w, n;
        t_big        bb, aa, ss, tt, rqw, pos;
        t_big        dax [3];
        logic [16:0] rq;
        t_status     st;
        logic        bec;
        t_out        r;
        a = '{sx(it.corner_a_x), sx(it.corner_a_y), sx(it.corner_a_z)};
        b = '{sx(it.corner_b_x), sx(it.corner_b_y), sx(it.corner_b_z)};
        c = '{sx(it.corner_c_x), sx(it.corner_c_y), sx(it.corner_c_z)};
        o = '{sx(ray_reg[0]), sx(ray_reg[1]), sx(ray_reg[2])};
        e = '{sx(ray_reg[3]), sx(ray_reg[4]), sx(ray_reg[5])};
        u = vsub(b, a);
        v = vsub(c, a);
        d = vsub(e, o);
        w = vsub(o, a);
        n = cross3(u, v);
        st = ST_MISS;
        bec = 1'b0;
        if (n.x == 0 && n.y == 0 && n.z == 0) begin
            st = ST_DEGEN;
        end else begin
            bb = dot3(d, n);
            aa = -dot3(w, n);
            if (bb == 0) begin
                st = (aa == 0) ? ST_PLANAR : ST_MISS;
            end else begin
                ss = dot3(d, cross3(w, v));
                tt = dot3(d, cross3(u, w));
                if (bb < 0) begin
                    bb = -bb;
                    aa = -aa;
                    ss = -ss;
                    tt = -tt;
                end
                if (aa >= 0 && ss >= 0 && ss <= bb && tt >= 0 && ss + tt <= bb) begin
                    st = ST_HIT;
                    if (aa >= bb + bb) begin
                        rq = '1;
                    end else begin
                        rqw = (aa <<< FRAC_W) / bb;
                        rq = rqw[16:0];
                    end
                    if (rq < best_r) begin
                        bec = 1'b1;
                        best_r = rq;
                        found = 1'b1;
                        rqw = rq;
                        dax[0] = d.x;
                        dax[1] = d.y;
                        dax[2] = d.z;
                        for (int i = 0; i < 3; i++) begin
                            pos = sx(ray_reg[i]) + ((dax[i] * rqw) >>> FRAC_W);
                            best_pt[i] = pos[31:0];
                        end
                        set_unit_normal(n);
                    end
                end
            end
        end
        r.triangle_status = st;
        r.became_nearest  = bec;
        r.have_hit        = found;
        r.hit_x           = best_pt[0];
        r.hit_y           = best_pt[1];
        r.hit_z           = best_pt[2];
        r.normal_x        = best_nrm[0];
        r.normal_y        = best_nrm[1];
        r.normal_z        = best_nrm[2];
        r.mesh_done       = it.final_triangle;
        if (it.final_triangle) begin
            best_r = BEST_ONE;
            found = 1'b0;
            for (int i = 0; i < 3; i++) begin
                best_pt[i] = '0;
                best_nrm[i] = '0;
            end
        end
        return r;
    endfunction

    function automatic int pick_gap(input bit calm);
        int p;
        if (calm) return 0;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // triangle driver
    int tri_gap = 0;
    bit tri_calm = 1'b0;
    always @(posedge i_clk) begin
        logic fire;
        logic vnext;
        fire = in_valid && !o_in_stall;
        vnext = in_valid;
        if (!i_rst_n) begin
            vnext = 1'b0;
        end else begin
            if (fire) hit_q = {hit_q, nearest_hit_step(in_data)};
            if ($urandom_range(0, 299) == 0) tri_calm = !tri_calm;
            if (!in_valid || fire) begin
                vnext = 1'b0;
                if (tri_gap > 0) begin
                    tri_gap--;
                end else if (tri_q.size() > 0) begin
                    in_data <= tri_q.pop_front();
                    vnext = 1'b1;
                    tri_gap = pick_gap(tri_calm);
                end
            end
        end
        in_valid <= vnext;
    end

    task automatic chk(input string label, input logic [31:0] exp_v, input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t %s expected %h actual %h", $time, label, exp_v, act_v);
            errors++;
        end
    endtask

    // result monitor
    int res_gap = 0;
    bit res_calm = 1'b0;
    always @(posedge i_clk) begin
        t_out ex;
        logic snext;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (hit_q.size() == 0) begin
                $display("%0t unexpected result expected none actual %h", $time, o_out_data);
                errors++;
            end else begin
                ex = hit_q.pop_front();
                chk("triangle_status", ex.triangle_status, o_out_data.triangle_status);
                chk("became_nearest", ex.became_nearest, o_out_data.became_nearest);
                chk("have_hit", ex.have_hit, o_out_data.have_hit);
                chk("hit_x", ex.hit_x, o_out_data.hit_x);
                chk("hit_y", ex.hit_y, o_out_data.hit_y);
                chk("hit_z", ex.hit_z, o_out_data.hit_z);
                chk("normal_x", ex.normal_x, o_out_data.normal_x);
                chk("normal_y", ex.normal_y, o_out_data.normal_y);
                chk("normal_z", ex.normal_z, o_out_data.normal_z);
                chk("mesh_done", ex.mesh_done, o_out_data.mesh_done);
            end
        end
        if ($urandom_range(0, 299) == 0) res_calm = !res_calm;
        if (res_gap > 0) begin
            res_gap--;
            snext = 1'b1;
        end else begin
            res_gap = pick_gap(res_calm);
            snext = res_gap > 0;
            if (snext) res_gap--;
        end
        out_stall <= snext;
    end

    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
            (cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ray_mesh_nearest_hit: mismatch");
            $finish;
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input t_coord val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        ray_reg[idx] = val;
        cfg_valid <= 1'b0;
    endtask

    task automatic program_ray(input t_coord sx_, sy, sz, ex, ey, ez);
        cfg_write(CFG_START_X, sx_);
        cfg_write(CFG_START_Y, sy);
        cfg_write(CFG_START_Z, sz);
        cfg_write(CFG_END_X, ex);
        cfg_write(CFG_END_Y, ey);
        cfg_write(CFG_END_Z, ez);
    endtask

    // sampled away from the rising edge so the driver has settled
    task automatic wait_idle();
        while (tri_q.size() > 0 || in_valid || hit_q.size() > 0) @(negedge i_clk);
    endtask

    function automatic longint rs(input int s);
        return longint'($urandom_range(0, 2 * s)) - s;
    endfunction

    function automatic t_in pack_tri(input longint pa [3], pb [3], pc [3], input bit fin);
        t_in t;
        t.corner_a_x = t_coord'(pa[0]);
        t.corner_a_y = t_coord'(pa[1]);
        t.corner_a_z = t_coord'(pa[2]);
        t.corner_b_x = t_coord'(pb[0]);
        t.corner_b_y = t_coord'(pb[1]);
        t.corner_b_z = t_coord'(pb[2]);
        t.corner_c_x = t_coord'(pc[0]);
        t.corner_c_y = t_coord'(pc[1]);
        t.corner_c_z = t_coord'(pc[2]);
        t.final_triangle = fin;
        return t;
    endfunction

    // triangle around the ray point at parameter k/16
    function automatic t_in mk_hit(input int k, input int spread, input bit fin);
        longint pa [3], pb [3], pc [3], p, dl;
        for (int i = 0; i < 3; i++) begin
            dl = longint'(ray_reg[i + 3]) - longint'(ray_reg[i]);
            p = longint'(ray_reg[i]) + ((dl * k) >>> 4);
            pa[i] = p + rs(spread);
            pb[i] = p + rs(spread);
            pc[i] = 2 * p - ((pa[i] + pb[i]) >>> 1);
        end
        return pack_tri(pa, pb, pc, fin);
    endfunction

    // shift = 0 puts the ray in the plane, otherwise parallel to it
    function automatic t_in mk_flat(input bit shift, input bit fin);
        longint pa [3], pb [3], pc [3], off;
        for (int i = 0; i < 3; i++) begin
            off = shift ? rs(1 << 18) : 0;
            pa[i] = longint'(ray_reg[i]) + off;
            pb[i] = longint'(ray_reg[i + 3]) + off;
            pc[i] = pa[i] + rs(1 << 20);
        end
        return pack_tri(pa, pb, pc, fin);
    endfunction

    function automatic t_in mk_degen(input bit fin);
        longint pa [3], pb [3], pc [3], dd;
        for (int i = 0; i < 3; i++) begin
            dd = rs(1 << 16);
            pa[i] = rs(1 << 24);
            pb[i] = pa[i] + dd;
            pc[i] = pa[i] + 2 * dd;
        end
        return pack_tri(pa, pb, pc, fin);
    endfunction

    function automatic t_in mk_noise(input bit fin);
        t_in t;
        t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, 1'b0};
        t.final_triangle = fin;
        return t;
    endfunction

    task automatic random_mesh(input int count);
        t_in prev;
        t_in t;
        bit  fin;
        int  p, spread;
        prev = mk_noise(1'b0);
        for (int i = 0; i < count; i++) begin
            fin = $urandom_range(0, 9) == 0;
            p = $urandom_range(0, 99);
            spread = $urandom_range(0, 4) != 0 ? $urandom_range(1, 4096)
                                                : $urandom_range(1, 1 << 20);
            if (p < 55) t = mk_hit($urandom_range(0, 20), spread, fin);
            else if (p < 62) begin
                t = prev;
                t.final_triangle = fin;
            end
            else if (p < 70) t = mk_flat(1'b0, fin);
            else if (p < 76) t = mk_flat(1'b1, fin);
            else if (p < 80) t = mk_degen(fin);
            else t = mk_noise(fin);
            tri_q = {tri_q, t};
            prev = t;
        end
        tri_q = {tri_q, mk_noise(1'b1)};
    endtask

    initial begin
        t_in t;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset ray: zero length, so nothing can be hit
        for (int i = 0; i < 6; i++) tri_q = {tri_q, mk_noise(i == 5)};
        wait_idle();

        program_ray('0, '0, '0, '0, '0, 32'sd10 << 16);
        tri_q = {tri_q, mk_hit(8, 1 << 16, 1'b0)};
        tri_q = {tri_q, mk_hit(8, 1 << 16, 1'b0)};
        tri_q = {tri_q, tri_q[$]};
        tri_q = {tri_q, mk_hit(4, 1 << 14, 1'b0)};
        tri_q = {tri_q, mk_hit(20, 1 << 16, 1'b0)};
        tri_q = {tri_q, mk_hit(16, 1 << 16, 1'b0)};
        tri_q = {tri_q, mk_hit(0, 1 << 16, 1'b0)};
        tri_q = {tri_q, mk_degen(1'b0)};
        tri_q = {tri_q, mk_flat(1'b0, 1'b0)};
        tri_q = {tri_q, mk_flat(1'b1, 1'b1)};
        tri_q = {tri_q, mk_hit(12, 1 << 12, 1'b1)};
        t = '1;
        tri_q = {tri_q, t};
        t = '0;
        tri_q = {tri_q, t};
        t = {{9{32'sh80000000}}, 1'b0};
        tri_q = {tri_q, t};
        t = {32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
             32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 1'b0};
        tri_q = {tri_q, t};
        t = {32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
             32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1'b1};
        tri_q = {tri_q, t};
        wait_idle();

        program_ray(32'sh80000000, 32'sh80000000, 32'sh80000000,
                    32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        random_mesh(40);
        wait_idle();
        program_ray(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                    32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        random_mesh(40);
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            program_ray(t_coord'(rs(1 << 22)), t_coord'(rs(1 << 22)), t_coord'(rs(1 << 22)),
                        t_coord'(rs(1 << 22)), t_coord'(rs(1 << 22)), t_coord'(rs(1 << 22)));
            random_mesh(230);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("ray_mesh_nearest_hit: match");
        end else begin
            $display("ray_mesh_nearest_hit: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
